FILE: sv/nfba_pkg.sv
package nfba_pkg;

  localparam int NFBA_ENTRIES = 1024;
  localparam int WORD_BITS = 32;
  localparam int BIT_W = 5;
  localparam int CMD_W = 2;
  localparam int ENTRY_W = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND    = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // position of the lowest set bit of a word, zero when the word is empty
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

FILE: sv/next_fit_bitmap_allocator_core.sv
// next-fit bitmap allocator over ENTRIES entries numbered from 1
//
// an item (command, entry_number) is taken at a rising edge with start high
// and busy low. each item gives exactly one result on found_entry, entry_free
// and status, held for one cycle and marked by done. the receiver cannot stall
// the block, so a result is never held back and the next item may be taken
// in the cycle in which a result is shown.
//
// the occupancy map sits in one synchronous memory of 32-bit words, one read
// and one write a cycle, read data registered.
// - mark, release, query: read, then in the read-modify-write state mark and
//   release modify and write back, query only reads; busy until the result
// - entry number out of range: result the next cycle, busy stays low
// - find: one word read per cycle in the scan state, from the pointer's word
//   round to it again
//
// after reset a clearing pass writes zeros to every word, one per cycle;
// busy is high meanwhile. the search pointer returns to entry 1.
module next_fit_bitmap_allocator_core
  import nfba_pkg::*;
#(
  parameter int ENTRIES = NFBA_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command,
  input  logic [ENTRY_W-1:0]  entry_number,
  output logic                done,
  output logic [ENTRY_W-1:0]  found_entry,
  output logic                entry_free,
  output logic [STATUS_W-1:0] status
);

  localparam int WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW = IW + BIT_W;
  localparam int CW = $clog2(WORDS + 1);
  localparam int LAST_BITS = ENTRIES - (WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    WORD_BITS'((33'd1 << LAST_BITS) - 33'd1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_RMW   = 4'b1000
  } state_t;

  state_t state;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [IW-1:0]        rd_addr;
  logic                 mem_we;
  logic [IW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [IW-1:0]        clr_addr;
  logic [XW-1:0]        ptr;
  logic [XW-1:0]        ent_idx;
  cmd_t                 cmd;
  logic [IW-1:0]        cur_word;
  logic [CW-1:0]        scan_cnt;

  logic                 accept;
  logic                 in_range;
  logic [XW-1:0]        in_idx;
  logic [IW-1:0]        nxt_word;
  logic [WORD_BITS-1:0] free_vec;
  logic [BIT_W-1:0]     hit_bit;
  logic [XW-1:0]        hit_idx;
  logic [BIT_W-1:0]     ent_bit;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(entry_number) >= 32'd1) && (32'(entry_number) <= 32'(ENTRIES));
  assign in_idx   = XW'(32'(entry_number) - 32'd1);
  assign nxt_word = (cur_word == IW'(WORDS - 1)) ? '0 : cur_word + IW'(1);
  assign ent_bit  = ent_idx[BIT_W-1:0];

  // free bits of the word under scan: padding beyond the last entry counts
  // as occupied, and on the first visit bits below the pointer are skipped
  always_comb begin
    free_vec = ~rd_data;
    if (cur_word == IW'(WORDS - 1)) begin
      free_vec = free_vec & LAST_MASK;
    end
    if (scan_cnt == '0) begin
      free_vec = free_vec & ~((WORD_BITS'(1) << ptr[BIT_W-1:0]) - WORD_BITS'(1));
    end
  end

  assign hit_bit = lowest_bit(free_vec);
  assign hit_idx = {cur_word, hit_bit};

  always_comb begin
    rd_addr = '0;
    mem_we  = 1'b0;
    wr_addr = ent_idx[XW-1:BIT_W];
    wr_data = rd_data;
    unique case (state)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_addr = (cmd_t'(command) == CMD_FIND) ? ptr[XW-1:BIT_W] : in_idx[XW-1:BIT_W];
      end
      S_SCAN: begin
        rd_addr = nxt_word;
      end
      S_RMW: begin
        mem_we = (cmd == CMD_MARK) || (cmd == CMD_RELEASE);
        if (cmd == CMD_MARK) begin
          wr_data = rd_data | (WORD_BITS'(1) << ent_bit);
        end else begin
          wr_data = rd_data & ~(WORD_BITS'(1) << ent_bit);
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IW'(1);
          if (clr_addr == IW'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd      <= cmd_t'(command);
            ent_idx  <= in_idx;
            cur_word <= ptr[XW-1:BIT_W];
            scan_cnt <= '0;
            if (cmd_t'(command) == CMD_FIND) begin
              state <= S_SCAN;
            end else if (in_range) begin
              state <= S_RMW;
            end else begin
              done        <= 1'b1;
              found_entry <= '0;
              entry_free  <= 1'b0;
              status      <= ST_RANGE;
            end
          end
        end
        S_SCAN: begin
          cur_word <= nxt_word;
          scan_cnt <= scan_cnt + CW'(1);
          if (free_vec != '0) begin
            ptr         <= hit_idx;
            state       <= S_IDLE;
            done        <= 1'b1;
            found_entry <= ENTRY_W'(32'(hit_idx) + 32'd1);
            entry_free  <= 1'b0;
            status      <= ST_OK;
          end else if (scan_cnt == CW'(WORDS)) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            found_entry <= '0;
            entry_free  <= 1'b0;
            status      <= ST_NONE;
          end
        end
        S_RMW: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          found_entry <= '0;
          entry_free  <= (cmd == CMD_QUERY) ? ~rd_data[ent_bit] : 1'b0;
          status      <= ST_OK;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  a_range_reply: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd_t'(command) != CMD_FIND) && !in_range
      |=> done && (status == ST_RANGE))
    else $error("out-of-range item did not answer with a range status");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR) || (state == S_RMW))
    else $error("map written outside clearing or read-modify-write");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_cnt <= CW'(WORDS)))
    else $error("find scan ran past one full round of the map");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (found_entry == '0) && !entry_free)
    else $error("failed item carries a found entry or free flag");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) |-> $past(accept, 2) || $past(state) == S_IDLE)
    else $error("two results for one item");

endmodule
